>>> src/tpt_pkg.sv
// tpt_pkg: shared constants, codes and types of the task priority table
// used by tpt_rank_cmp, tpt_slot_mem and task_priority_table_core
`timescale 1ns / 1ps
`default_nettype none

package tpt_pkg;

  // default sizes, handed to the top level parameters
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W_DEF    = 16;
  localparam int PRIO_W_DEF   = 16;

  // fixed field widths
  localparam int STAMP_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  // command codes carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

  // status codes carried on out_tuser
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RETURNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd5;

  // verdict of the shared compare unit on one slot
  typedef struct packed {
    logic ahead;   // slot ranks ahead of the current best
    logic key_eq;  // slot key equals the requested key
  } cmp_res_t;

endpackage

`default_nettype wire

>>> src/tpt_rank_cmp.sv
// tpt_rank_cmp: shared compare unit, one slot against the running best
// and against the requested key; depends on tpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpt_rank_cmp #(
  parameter int KEY_WIDTH  = tpt_pkg::KEY_W_DEF,
  parameter int PRIO_WIDTH = tpt_pkg::PRIO_W_DEF
) (
  input  wire logic [KEY_WIDTH-1:0]        slot_key,
  input  wire logic [PRIO_WIDTH-1:0]       slot_prio,
  input  wire logic [tpt_pkg::STAMP_W-1:0] slot_stamp,
  input  wire logic [KEY_WIDTH-1:0]        req_key,
  input  wire logic [PRIO_WIDTH-1:0]       best_prio,
  input  wire logic [tpt_pkg::STAMP_W-1:0] best_stamp,
  output tpt_pkg::cmp_res_t                res
);
  import tpt_pkg::*;

  logic prio_gt;
  logic prio_eq;

  // higher signed priority first, newer stamp among ties, strict so the
  // lower slot keeps its place on a full tie
  assign prio_gt    = $signed(slot_prio) > $signed(best_prio);
  assign prio_eq    = slot_prio == best_prio;
  assign res.ahead  = prio_gt || (prio_eq && (slot_stamp > best_stamp));
  assign res.key_eq = slot_key == req_key;

endmodule

`default_nettype wire

>>> src/tpt_slot_mem.sv
// tpt_slot_mem: slot store for key, priority and stamp, one write and one
// registered read per cycle; depends on tpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpt_slot_mem #(
  parameter int CAPACITY   = tpt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH  = tpt_pkg::KEY_W_DEF,
  parameter int PRIO_WIDTH = tpt_pkg::PRIO_W_DEF,
  localparam int IDX_W     = $clog2(CAPACITY)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [IDX_W-1:0]            wr_addr,
  input  wire logic [KEY_WIDTH-1:0]        wr_key,
  input  wire logic [PRIO_WIDTH-1:0]       wr_prio,
  input  wire logic [tpt_pkg::STAMP_W-1:0] wr_stamp,
  input  wire logic [IDX_W-1:0]            rd_addr,
  output logic      [KEY_WIDTH-1:0]        rd_key,
  output logic      [PRIO_WIDTH-1:0]       rd_prio,
  output logic      [tpt_pkg::STAMP_W-1:0] rd_stamp
);
  import tpt_pkg::*;

  localparam int ENTRY_W = KEY_WIDTH + PRIO_WIDTH + STAMP_W;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_stamp, wr_prio, wr_key};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_key   = rd_data_r[KEY_WIDTH-1:0];
  assign rd_prio  = rd_data_r[KEY_WIDTH +: PRIO_WIDTH];
  assign rd_stamp = rd_data_r[KEY_WIDTH+PRIO_WIDTH +: STAMP_W];

endmodule

`default_nettype wire

>>> src/task_priority_table_core.sv
// task_priority_table_core: top level of the keyed task priority table
// depends on tpt_pkg, tpt_rank_cmp and tpt_slot_mem
`timescale 1ns / 1ps
`default_nettype none

// Keyed priority table of up to CAPACITY tasks. An input item carries a
// command on in_tuser (add, get, list) and a task key and signed priority
// on in_tdata. Add inserts the key in the lowest free slot, or replaces
// the priority of a key already held, and stamps it with a running 32-bit
// sequence number; a full table answers with status full and keeps its
// contents. Get removes and returns the highest priority task, newest
// stamp first among equal priorities. List returns every held task in
// that order without removing any, with out_tlast on the final one; get
// and list on an empty table return one empty item. Command code 3 is
// ignored and gives no result. Timing: the slot store has one read port,
// so each pass reads one slot per cycle through a single compare unit. An
// add or get runs one such pass from acceptance to its result
// (CAPACITY reads, one compare stage, one commit), a list with n held
// tasks runs n passes, an empty list one pass, and command code 3 no
// pass at all. in_tready is high only between items. The
// result sits in an output register, so the next item is taken while a
// result still waits; the commit step waits only if that register is
// still full. Valid bits live in flip-flops cleared by reset, so no
// clearing pass is needed after reset.
module task_priority_table_core #(
  parameter int CAPACITY   = tpt_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH  = tpt_pkg::KEY_W_DEF,
  parameter int PRIO_WIDTH = tpt_pkg::PRIO_W_DEF,
  localparam int DATA_W    = ((KEY_WIDTH + PRIO_WIDTH + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input item channel
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [DATA_W-1:0]           in_tdata,   // task_id, priority_req, zero pad
  input  wire logic [tpt_pkg::CMD_W-1:0]   in_tuser,   // cmd
  // result item channel
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [DATA_W-1:0]           out_tdata,  // task_id_res, priority_res, zero pad
  output logic      [tpt_pkg::STATUS_W-1:0] out_tuser, // status
  output logic                             out_tlast   // last
);
  import tpt_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] S_SCAN = 2'd1;  // one slot read and compared per cycle
  localparam logic [1:0] S_DONE = 2'd2;  // commit and load the result

  logic [1:0]            state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0]  key_r, key_nxt;
  logic [PRIO_WIDTH-1:0] prio_r, prio_nxt;

  // scan pipeline: read issue counter, then the compare stage
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0] p_idx_r, p_idx_nxt;
  logic             p_last_r, p_last_nxt;

  // scan findings
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic                  free_r, free_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic                  best_r, best_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [KEY_WIDTH-1:0]  best_key_r, best_key_nxt;
  logic [PRIO_WIDTH-1:0] best_prio_r, best_prio_nxt;
  logic [STAMP_W-1:0]    best_stamp_r, best_stamp_nxt;

  // table control state
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] listed_r, listed_nxt;   // already emitted in this list
  logic [CNT_W-1:0]    count_r, count_nxt;     // slots held
  logic [CNT_W-1:0]    remain_r, remain_nxt;   // list entries still to emit
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;

  // output register
  logic                  ovld_r, ovld_nxt;
  logic [STATUS_W-1:0]   ostat_r, ostat_nxt;
  logic [KEY_WIDTH-1:0]  okey_r, okey_nxt;
  logic [PRIO_WIDTH-1:0] oprio_r, oprio_nxt;
  logic                  olast_r, olast_nxt;

  // slot store and compare unit hookup
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wr_addr;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [PRIO_WIDTH-1:0] rd_prio;
  logic [STAMP_W-1:0]    rd_stamp;
  cmp_res_t              cmp;

  logic out_free;
  logic slot_on;
  logic eligible;
  logic add_commit;

  tpt_slot_mem #(
    .CAPACITY   (CAPACITY),
    .KEY_WIDTH  (KEY_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_wr_addr),
    .wr_key   (key_r),
    .wr_prio  (prio_r),
    .wr_stamp (stamp_r),
    .rd_addr  (idx_r[IDX_W-1:0]),
    .rd_key   (rd_key),
    .rd_prio  (rd_prio),
    .rd_stamp (rd_stamp)
  );

  tpt_rank_cmp #(
    .KEY_WIDTH  (KEY_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_cmp (
    .slot_key   (rd_key),
    .slot_prio  (rd_prio),
    .slot_stamp (rd_stamp),
    .req_key    (key_r),
    .best_prio  (best_prio_r),
    .best_stamp (best_stamp_r),
    .res        (cmp)
  );

  assign in_tready   = state_r == S_IDLE;
  assign out_free    = !ovld_r || out_tready;
  assign slot_on     = valid_r[p_idx_r];
  assign eligible    = slot_on && !listed_r[p_idx_r];
  assign mem_wr_addr = hit_r ? hit_idx_r : free_idx_r;
  assign add_commit  = (state_r == S_DONE) && out_free && (cmd_r == CMD_ADD)
                       && (hit_r || free_r);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    prio_nxt       = prio_r;
    idx_nxt        = idx_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = p_idx_r;
    p_last_nxt     = 1'b0;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_prio_nxt  = best_prio_r;
    best_stamp_nxt = best_stamp_r;
    valid_nxt      = valid_r;
    listed_nxt     = listed_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    stamp_nxt      = stamp_r;
    ovld_nxt       = ovld_r && !out_tready;
    ostat_nxt      = ostat_r;
    okey_nxt       = okey_r;
    oprio_nxt      = oprio_r;
    olast_nxt      = olast_r;
    mem_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_tuser;
          key_nxt    = in_tdata[KEY_WIDTH-1:0];
          prio_nxt   = in_tdata[KEY_WIDTH +: PRIO_WIDTH];
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          best_nxt   = 1'b0;
          // list marks only matter within one list, every item starts clean
          listed_nxt = '0;
          unique case (in_tuser)
            CMD_ADD, CMD_GET: begin
              state_nxt = S_SCAN;
            end
            CMD_LIST: begin
              state_nxt  = S_SCAN;
              remain_nxt = count_r;
            end
            default: begin
              state_nxt = S_IDLE;  // unused command, no result
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next slot read
        if (idx_r != CNT_W'(CAPACITY)) begin
          p_vld_nxt  = 1'b1;
          p_idx_nxt  = idx_r[IDX_W-1:0];
          p_last_nxt = idx_r == CNT_W'(CAPACITY - 1);
          idx_nxt    = idx_r + CNT_W'(1);
        end
        // compare the slot read in the previous cycle
        if (p_vld_r) begin
          if (cmd_r == CMD_ADD) begin
            if (slot_on && !hit_r && cmp.key_eq) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = p_idx_r;
            end
            if (!slot_on && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = p_idx_r;
            end
          end else if (eligible && (!best_r || cmp.ahead)) begin
            best_nxt       = 1'b1;
            best_idx_nxt   = p_idx_r;
            best_key_nxt   = rd_key;
            best_prio_nxt  = rd_prio;
            best_stamp_nxt = rd_stamp;
          end
          if (p_last_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          okey_nxt  = '0;
          oprio_nxt = '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_ADD: begin
              priority if (hit_r) begin
                mem_we    = 1'b1;
                stamp_nxt = stamp_r + STAMP_W'(1);
                ostat_nxt = ST_REPLACED;
              end else if (free_r) begin
                mem_we               = 1'b1;
                stamp_nxt            = stamp_r + STAMP_W'(1);
                valid_nxt[free_idx_r] = 1'b1;
                count_nxt            = count_r + CNT_W'(1);
                ostat_nxt            = ST_INSERTED;
              end else begin
                ostat_nxt = ST_FULL;
              end
            end
            CMD_GET: begin
              if (best_r) begin
                valid_nxt[best_idx_r] = 1'b0;
                count_nxt             = count_r - CNT_W'(1);
                ostat_nxt             = ST_RETURNED;
                okey_nxt              = best_key_r;
                oprio_nxt             = best_prio_r;
              end else begin
                ostat_nxt = ST_EMPTY;
              end
            end
            CMD_LIST: begin
              if (best_r) begin
                listed_nxt[best_idx_r] = 1'b1;
                remain_nxt             = remain_r - CNT_W'(1);
                ostat_nxt              = ST_LISTED;
                okey_nxt               = best_key_r;
                oprio_nxt              = best_prio_r;
                olast_nxt              = remain_r == CNT_W'(1);
                if (remain_r != CNT_W'(1)) begin
                  // another selection pass for the next entry
                  state_nxt = S_SCAN;
                  idx_nxt   = '0;
                  best_nxt  = 1'b0;
                end
              end else begin
                ostat_nxt = ST_EMPTY;
              end
            end
            default: begin
              ovld_nxt = ovld_r && !out_tready;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      p_vld_r  <= 1'b0;
      p_last_r <= 1'b0;
      valid_r  <= '0;
      listed_r <= '0;
      count_r  <= '0;
      remain_r <= '0;
      stamp_r  <= '0;
      ovld_r   <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      best_r   <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      p_vld_r  <= p_vld_nxt;
      p_last_r <= p_last_nxt;
      valid_r  <= valid_nxt;
      listed_r <= listed_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      stamp_r  <= stamp_nxt;
      ovld_r   <= ovld_nxt;
      hit_r    <= hit_nxt;
      free_r   <= free_nxt;
      best_r   <= best_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    prio_r       <= prio_nxt;
    p_idx_r      <= p_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_key_r   <= best_key_nxt;
    best_prio_r  <= best_prio_nxt;
    best_stamp_r <= best_stamp_nxt;
    ostat_r      <= ostat_nxt;
    okey_r       <= okey_nxt;
    oprio_r      <= oprio_nxt;
    olast_r      <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = DATA_W'({oprio_r, okey_r});
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

  // fill count never runs past the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // a get or list always picks a held slot not yet listed
  a_best_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && cmd_r != CMD_ADD && best_r)
      |-> (valid_r[best_idx_r] && !listed_r[best_idx_r]))
    else $error("selected slot is not held");

  // the stamp moves only on an insert or replace
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (stamp_r != $past(stamp_r)) |-> $past(add_commit))
    else $error("stamp advanced without an add");

  // a returned task lowers the fill count by one
  a_get_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free && cmd_r == CMD_GET && best_r)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("get did not free a slot");

  // while a list is still under way no new item is taken
  a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && ostat_r == ST_LISTED && !olast_r) |-> !in_tready)
    else $error("item accepted during a list");

endmodule

`default_nettype wire

>>> bench/tpt_table_checker.sv
// tpt_table_checker: watches both item channels of the task priority table,
// predicts every result item and compares it field by field; uses tpt_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpt_table_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,   // task_id, priority_req
  input  wire logic [1:0]  in_tuser,   // cmd
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // task_id_res, priority_res
  input  wire logic [2:0]  out_tuser,  // status
  input  wire logic        out_tlast,  // last
  output int               errors,
  output int               pending,
  output int               checked,
  output int               full_seen,
  output int               replaced_seen,
  output int               listed_seen
);

  localparam int CAP = tpt_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id;
    logic [15:0] prio;
    logic        last;
  } table_result_t;

  table_result_t awaited_results[$];

  // shadow copy of the table
  logic               held[CAP];
  logic [15:0]        held_key[CAP];
  logic signed [15:0] held_prio[CAP];
  logic [31:0]        held_stamp[CAP];
  logic [31:0]        next_stamp;

  // higher priority first, then newest stamp, then lowest slot
  function automatic logic serves_first(int a, int b);
    if (held_prio[a] != held_prio[b]) return held_prio[a] > held_prio[b];
    if (held_stamp[a] != held_stamp[b]) return held_stamp[a] > held_stamp[b];
    return a < b;
  endfunction

  // append one awaited result at the tail of the queue
  function automatic void await_result(table_result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic [15:0] key,
                                        logic signed [15:0] prio);
    int hit;
    int spare;
    int best;
    int n;
    int j;
    int order[CAP];
    table_result_t r;
    hit = -1;
    spare = -1;
    best = -1;
    n = 0;
    r = '0;
    r.last = 1'b1;
    case (cmd)
      tpt_pkg::CMD_ADD: begin
        for (int i = 0; i < CAP; i++) begin
          if (held[i]) begin
            if (hit < 0 && held_key[i] == key) hit = i;
          end else if (spare < 0) begin
            spare = i;
          end
        end
        if (hit >= 0) begin
          held_prio[hit] = prio;
          held_stamp[hit] = next_stamp;
          next_stamp++;
          r.status = tpt_pkg::ST_REPLACED;
        end else if (spare >= 0) begin
          held[spare] = 1'b1;
          held_key[spare] = key;
          held_prio[spare] = prio;
          held_stamp[spare] = next_stamp;
          next_stamp++;
          r.status = tpt_pkg::ST_INSERTED;
        end else begin
          r.status = tpt_pkg::ST_FULL;
        end
        await_result(r);
      end
      tpt_pkg::CMD_GET: begin
        for (int i = 0; i < CAP; i++)
          if (held[i] && (best < 0 || serves_first(i, best))) best = i;
        if (best < 0) begin
          r.status = tpt_pkg::ST_EMPTY;
        end else begin
          held[best] = 1'b0;
          r.status = tpt_pkg::ST_RETURNED;
          r.id = held_key[best];
          r.prio = held_prio[best];
        end
        await_result(r);
      end
      tpt_pkg::CMD_LIST: begin
        // insertion sort of the held slots into serving order
        for (int i = 0; i < CAP; i++) begin
          if (held[i]) begin
            j = n;
            while (j > 0 && serves_first(i, order[j-1])) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i;
            n++;
          end
        end
        if (n == 0) begin
          r.status = tpt_pkg::ST_EMPTY;
          await_result(r);
        end
        for (int k = 0; k < n; k++) begin
          r.status = tpt_pkg::ST_LISTED;
          r.id = held_key[order[k]];
          r.prio = held_prio[order[k]];
          r.last = (k == n - 1);
          await_result(r);
        end
      end
      default: ;  // unused code, no result
    endcase
  endfunction

  always @(posedge clk) begin
    table_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < CAP; i++) held[i] = 1'b0;
      next_stamp = '0;
      awaited_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        apply_command(in_tuser, in_tdata[15:0], in_tdata[31:16]);
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $error("unexpected result item: status %0d id %0d prio %0d last %0b",
                 out_tuser, out_tdata[15:0], $signed(out_tdata[31:16]), out_tlast);
        end else begin
          exp_r = awaited_results.pop_front();
          checked++;
          if (out_tuser == tpt_pkg::ST_FULL) full_seen++;
          if (out_tuser == tpt_pkg::ST_REPLACED) replaced_seen++;
          if (out_tuser == tpt_pkg::ST_LISTED) listed_seen++;
          if (out_tuser !== exp_r.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", exp_r.status, out_tuser);
          end
          if (out_tdata[15:0] !== exp_r.id) begin
            errors++;
            $error("task_id_res: expected %0d, actual %0d", exp_r.id, out_tdata[15:0]);
          end
          if (out_tdata[31:16] !== exp_r.prio) begin
            errors++;
            $error("priority_res: expected %0d, actual %0d",
                   $signed(exp_r.prio), $signed(out_tdata[31:16]));
          end
          if (out_tlast !== exp_r.last) begin
            errors++;
            $error("last: expected %0b, actual %0b", exp_r.last, out_tlast);
          end
        end
      end
    end
    pending = awaited_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    full_seen = 0;
    replaced_seen = 0;
    listed_seen = 0;
  end

endmodule

`default_nettype wire

>>> bench/task_priority_table_core_tb.sv
// task_priority_table_core_tb: stimulus and verdict for the task priority table
// depends on tpt_pkg, task_priority_table_core and tpt_table_checker
`timescale 1ns / 1ps
`default_nettype none

module task_priority_table_core_tb;

  // command code 3 is accepted and ignored by the block
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_PCT = 21;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // task_id, priority_req
  logic [1:0]  in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // task_id_res, priority_res
  logic [2:0]  out_tuser;  // status
  logic        out_tlast;  // last

  int errors;
  int pending;
  int checked;
  int full_seen;
  int replaced_seen;
  int listed_seen;

  // calm stretches switch off idling on one side
  logic calm_tx;
  logic calm_rx;
  int   sent;
  int   ignored;

  task_priority_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  tpt_table_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .full_seen     (full_seen),
    .replaced_seen (replaced_seen),
    .listed_seen   (listed_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure except in its calm stretch
  always @(negedge clk) begin
    out_tready <= calm_rx || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // drive one item from a falling edge and return at the falling edge after
  // its acceptance; valid stays high so the next call can follow at once
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] key,
                           input logic [15:0] prio);
    while (!calm_tx && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {prio, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_NONE) ignored++;
    else sent++;
  endtask

  // hold the sender until every awaited result item has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly a small key pool so the table fills, replaces and hits
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 70) return 16'($urandom_range(0, 23));
    return 16'($urandom_range(0, 65535));
  endfunction

  // clustered priorities give ties, plus extremes and full-range values
  function automatic logic [15:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 6) - 3);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    int add_pct;
    int r;
    int done;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = tpt_pkg::CMD_ADD;
    calm_tx    = 1'b0;
    calm_rx    = 1'b0;
    sent       = 0;
    ignored    = 0;
    add_pct    = 55;
    done       = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, ignored code, extremes, ties, replace, full
    send_item(tpt_pkg::CMD_GET, 16'h0000, 16'h0000);
    send_item(tpt_pkg::CMD_LIST, 16'h0000, 16'h0000);
    send_item(CMD_NONE, 16'hffff, 16'hffff);
    send_item(tpt_pkg::CMD_ADD, 16'h0000, 16'h8000);
    send_item(tpt_pkg::CMD_ADD, 16'hffff, 16'h7fff);
    send_item(tpt_pkg::CMD_ADD, 16'h5a5a, 16'h0000);
    send_item(tpt_pkg::CMD_ADD, 16'ha5a5, 16'h0000);
    send_item(tpt_pkg::CMD_ADD, 16'h0000, 16'h0005);
    send_item(tpt_pkg::CMD_LIST, 16'h0000, 16'h0000);
    // fill the remaining slots, some sharing a priority
    for (int i = 0; i < 12; i++)
      send_item(tpt_pkg::CMD_ADD, 16'(100 + i), 16'(i % 3 - 1));
    send_item(tpt_pkg::CMD_ADD, 16'h1234, 16'h7fff);   // full, dropped
    send_item(tpt_pkg::CMD_ADD, 16'd100, 16'hfffe);    // replace while full
    send_item(tpt_pkg::CMD_LIST, 16'h0000, 16'h0000);
    send_item(tpt_pkg::CMD_GET, 16'h0000, 16'h0000);

    // random: segments lean toward filling or draining the table
    while (done < RANDOM_ITEMS) begin
      if (done % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 25;
          1: add_pct = 55;
          default: add_pct = 85;
        endcase
      end
      calm_tx = (done >= 150 && done < 230);
      calm_rx = (done >= 300 && done < 360);
      if (done == 200 && r != -1) begin
        drain_results();
        r = -1;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(CMD_NONE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end else if (r < add_pct) begin
        send_item(tpt_pkg::CMD_ADD, pick_key(), pick_prio());
        done++;
      end else if ($urandom_range(0, 3) != 0) begin
        send_item(tpt_pkg::CMD_GET, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        done++;
      end else begin
        send_item(tpt_pkg::CMD_LIST, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
        done++;
      end
    end
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    in_tvalid <= 1'b0;

    // wait for the last results, then allow a full list pass for strays
    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);

    $display("run covered %0d commands and %0d ignored codes, %0d result items checked",
             sent, ignored, checked);
    $display("of which %0d replaced, %0d dropped on a full table, %0d list entries",
             replaced_seen, full_seen, listed_seen);
    if (errors == 0 && pending == 0)
      $display("task_priority_table_core: match");
    else
      $display("task_priority_table_core: mismatch");
    $finish;
  end

  // generous cap on the whole run
  initial begin
    #(10_000_000);
    $display("task_priority_table_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
